// ===== hdl/mpfb_pkg.sv =====
// Package for the monochrome page frame store.
// Holds geometry constants, field widths, operation codes and the byte address function.
// No dependencies.
package mpfb_pkg;

  localparam int SCREEN_WIDTH = 128;
  localparam int MAX_ROWS     = 64;
  localparam int STORE_BYTES  = (SCREEN_WIDTH * MAX_ROWS) / 8;
  localparam int ADDR_W       = $clog2(STORE_BYTES);

  // field widths of the words on the two channels
  localparam int OP_W    = 3;
  localparam int X_W     = 8;
  localparam int Y_W     = 7;
  localparam int PAT_W   = 8;
  localparam int NBITS_W = 4;
  localparam int BIDX_W  = 10;
  localparam int BYTE_W  = 8;

  // column after adding a blit offset of up to seven
  localparam int COL_W = X_W + 1;
  // width that holds any panel height up to MAX_ROWS
  localparam int ROW_LIM_W = Y_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW      = 3'd0,
    OP_READ_PIX  = 3'd1,
    OP_FILL      = 3'd2,
    OP_BLIT      = 3'd3,
    OP_READ_BYTE = 3'd4
  } op_e;

  // byte holding pixel (col,row): col + (row/8) * width
  function automatic logic [ADDR_W-1:0] byte_addr(input logic [COL_W-1:0] col,
                                                 input logic [Y_W-1:0] row);
    return ADDR_W'(int'(col) + int'(row >> 3) * SCREEN_WIDTH);
  endfunction

endpackage

// ===== hdl/mpfb_if.sv =====
// Channel interfaces for the monochrome page frame store: request and response words.
// Depends on mpfb_pkg.
interface mpfb_req_if;
  import mpfb_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [X_W-1:0]     x;
  logic [Y_W-1:0]     y;
  logic               color;
  logic [PAT_W-1:0]   pattern;
  logic [NBITS_W-1:0] pattern_bits;
  logic [BIDX_W-1:0]  byte_index;

  modport source (output valid, op, x, y, color, pattern, pattern_bits, byte_index,
                  input ready);
  modport sink (input valid, op, x, y, color, pattern, pattern_bits, byte_index,
                output ready);
endinterface

interface mpfb_rsp_if;
  import mpfb_pkg::*;

  logic              valid;
  logic              ready;
  logic              pixel_on;
  logic [BYTE_W-1:0] byte_value;
  logic              in_range;

  modport source (output valid, pixel_on, byte_value, in_range, input ready);
  modport sink (input valid, pixel_on, byte_value, in_range, output ready);
endinterface

// ===== hdl/mpfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpfb_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/mono_page_framebuffer_core.sv =====
// Monochrome page-layout frame store, one bit per pixel, with its sequencer.
// Depends on mpfb_pkg, mpfb_req_if, mpfb_rsp_if and mpfb_ram.
//
// Usage
//   req_i carries one operation word: draw pixel, read pixel, fill, blit byte or
//   read byte. rsp_o returns exactly one word per request (pixel_on, byte_value,
//   in_range). Both use valid/ready; a word moves on a clock edge with both high.
//   cfg_we_i/cfg_wdata_i write the panel height select (0: 32 rows, 1: 64 rows);
//   write it only while the block is idle.
// Sequence (request accepted to response word valid)
//   read pixel, read byte: S_READ, S_RESP; draw pixel: S_MODIFY, S_RESP; off screen
//   or out of range: S_RESP only. fill: S_FILL over each byte in use, then S_RESP.
//   blit: an S_BLIT step per pattern bit examined, an S_MODIFY per pixel drawn, S_RESP;
//   every pixel drawn is a read-modify-write through the one RAM port pair.
//   The block takes one request at a time: req_i.ready is high only while idle.
// Reset
//   After rst_ni rises the sequencer sweeps the store to zero, one byte per cycle,
//   through all STORE_BYTES (1024) bytes; no request is taken meanwhile.
// Stalls
//   The response is held in an output register. The next request is accepted
//   while it waits; that request finishes its work and then holds until the
//   pending response word has been taken.
module mono_page_framebuffer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  mpfb_req_if.sink   req_i,
  mpfb_rsp_if.source rsp_o
);
  import mpfb_pkg::*;

  // panel geometry for the two heights, clamped to the store
  localparam int ROWS_HI = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int ROWS_LO = (MAX_ROWS < 32) ? MAX_ROWS : 32;
  localparam int USED_HI = (SCREEN_WIDTH * ROWS_HI) / 8;
  localparam int USED_LO = (SCREEN_WIDTH * ROWS_LO) / 8;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_BLIT,
    S_READ,
    S_MODIFY,
    S_RESP
  } state_e;

  state_e               state_q;
  logic [ADDR_W-1:0]    cnt_q;
  logic [NBITS_W-1:0]   k_q;
  logic [NBITS_W-1:0]   nbits_q;
  op_e                  op_q;
  logic [X_W-1:0]       x_q;
  logic [Y_W-1:0]       y_q;
  logic                 color_q;
  logic [PAT_W-1:0]     pattern_q;
  logic                 row_ok_q;
  logic [ADDR_W-1:0]    addr_q;
  logic                 res_pix_q;
  logic [BYTE_W-1:0]    res_byte_q;
  logic                 res_inr_q;
  logic                 rows_sixty_four_q;
  logic                 out_valid_q;
  logic                 out_pix_q;
  logic [BYTE_W-1:0]    out_byte_q;
  logic                 out_inr_q;

  logic [ROW_LIM_W-1:0] height;
  logic [ADDR_W-1:0]    last_used;
  logic                 byte_ok;
  logic                 x_on;
  logic                 y_on;
  logic [COL_W-1:0]     blit_col;
  logic                 blit_done;
  logic                 blit_hit;
  logic [COL_W-1:0]     ua_col;
  logic [Y_W-1:0]       ua_row;
  logic [ADDR_W-1:0]    ua_addr;
  logic [BYTE_W-1:0]    bit_mask;
  logic                 req_fire;
  logic                 rsp_load;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [BYTE_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [BYTE_W-1:0]    ram_rdata;

  // panel size in use
  assign height    = rows_sixty_four_q ? ROW_LIM_W'(ROWS_HI) : ROW_LIM_W'(ROWS_LO);
  assign last_used = rows_sixty_four_q ? ADDR_W'(USED_HI - 1) : ADDR_W'(USED_LO - 1);
  assign byte_ok   = 32'(req_i.byte_index) < (rows_sixty_four_q ? USED_HI : USED_LO);

  // clipping of the incoming pixel
  assign x_on = {1'b0, req_i.x} < COL_W'(SCREEN_WIDTH);
  assign y_on = {1'b0, req_i.y} < height;

  // blit walk: pattern bit 7 sits at column x, bit 7-k at column x+k
  assign blit_col  = {1'b0, x_q} + COL_W'(k_q);
  assign blit_done = (k_q == nbits_q);
  assign blit_hit  = pattern_q[~k_q[2:0]] && (blit_col < COL_W'(SCREEN_WIDTH)) && row_ok_q;

  // shared address unit: take the live request while idle, the blit column otherwise
  always_comb begin
    if (state_q == S_IDLE) begin
      ua_col = {1'b0, req_i.x};
      ua_row = req_i.y;
    end else begin
      ua_col = blit_col;
      ua_row = y_q;
    end
  end
  assign ua_addr  = byte_addr(ua_col, ua_row);
  assign bit_mask = BYTE_W'(1) << y_q[2:0];

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_load    = (state_q == S_RESP) && (!out_valid_q || rsp_o.ready);

  // RAM port control: sweep writes, read-modify-write of one pixel, byte read address
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    ram_raddr = ua_addr;
    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {BYTE_W{color_q}};
      end
      S_MODIFY: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = color_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
      end
      S_IDLE: begin
        if (op_e'(req_i.op) == OP_READ_BYTE) begin
          ram_raddr = ADDR_W'(req_i.byte_index);
        end
      end
      default: begin
      end
    endcase
  end

  mpfb_ram #(
    .DEPTH(STORE_BYTES),
    .WIDTH(BYTE_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_CLEAR;
      cnt_q             <= '0;
      k_q               <= '0;
      nbits_q           <= '0;
      op_q              <= OP_DRAW;
      rows_sixty_four_q <= 1'b1;
      out_valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rows_sixty_four_q <= cfg_wdata_i;
      end

      // drop the response word once taken; a load below overrides this
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          if (cnt_q == ADDR_W'(STORE_BYTES - 1)) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end

        S_IDLE: begin
          if (req_fire) begin
            op_q       <= op_e'(req_i.op);
            x_q        <= req_i.x;
            y_q        <= req_i.y;
            color_q    <= req_i.color;
            pattern_q  <= req_i.pattern;
            nbits_q    <= (req_i.pattern_bits > NBITS_W'(8)) ? NBITS_W'(8)
                                                             : req_i.pattern_bits;
            k_q        <= '0;
            row_ok_q   <= y_on;
            addr_q     <= ua_addr;
            res_pix_q  <= 1'b0;
            res_byte_q <= '0;
            res_inr_q  <= x_on && y_on;
            unique case (op_e'(req_i.op))
              OP_DRAW:      state_q <= (x_on && y_on) ? S_MODIFY : S_RESP;
              OP_READ_PIX:  state_q <= (x_on && y_on) ? S_READ : S_RESP;
              OP_FILL: begin
                cnt_q     <= '0;
                res_inr_q <= 1'b1;
                state_q   <= S_FILL;
              end
              OP_BLIT:      state_q <= S_BLIT;
              OP_READ_BYTE: begin
                res_inr_q <= byte_ok;
                state_q   <= byte_ok ? S_READ : S_RESP;
              end
              default: begin
                res_inr_q <= 1'b0;
                state_q   <= S_RESP;
              end
            endcase
          end
        end

        S_FILL: begin
          if (cnt_q == last_used) begin
            cnt_q   <= '0;
            state_q <= S_RESP;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end

        S_BLIT: begin
          priority if (blit_done) begin
            state_q <= S_RESP;
          end else begin
            k_q <= k_q + 1'b1;
            if (blit_hit) begin
              addr_q  <= ua_addr;
              state_q <= S_MODIFY;
            end
          end
        end

        S_MODIFY: begin
          state_q <= (op_q == OP_BLIT) ? S_BLIT : S_RESP;
        end

        S_READ: begin
          if (op_q == OP_READ_PIX) begin
            res_pix_q <= ram_rdata[y_q[2:0]];
          end else begin
            res_byte_q <= ram_rdata;
          end
          state_q <= S_RESP;
        end

        S_RESP: begin
          if (rsp_load) begin
            out_valid_q <= 1'b1;
            out_pix_q   <= res_pix_q;
            out_byte_q  <= res_byte_q;
            out_inr_q   <= res_inr_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.pixel_on   = out_pix_q;
  assign rsp_o.byte_value = out_byte_q;
  assign rsp_o.in_range   = out_inr_q;

endmodule

// ===== hdl/mpfb_checker.sv =====
// Port-level checks for the monochrome page frame store, and the bind that attaches them.
// Depends on mpfb_pkg and mono_page_framebuffer_core.
module mpfb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_pixel_on_i,
  input logic [mpfb_pkg::BYTE_W-1:0] out_byte_value_i,
  input logic                       out_in_range_i
);
  import mpfb_pkg::*;

  // the clearing sweep blocks requests right after reset
  a_clear_blocks: assert property (@(posedge clk_i)
    !$past(rst_ni) && rst_ni |-> !in_ready_i)
    else $error("request accepted during the clearing sweep");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while the previous one is still at work");

  // no data for an out-of-range address
  a_zero_off_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_in_range_i |-> !out_pixel_on_i && (out_byte_value_i == '0))
    else $error("response data set for an out-of-range address");

  // hold the response word while stalled
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pixel_on_i)
      && $stable(out_byte_value_i) && $stable(out_in_range_i))
    else $error("response word changed or dropped while stalled");

endmodule

bind mono_page_framebuffer_core mpfb_checker u_mpfb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .out_pixel_on_i  (rsp_o.pixel_on),
  .out_byte_value_i(rsp_o.byte_value),
  .out_in_range_i  (rsp_o.in_range)
);
